// File: src/nvis_pkg.sv
// Shared types and codes for the nearest value index search block.
package nvis_pkg;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  localparam int IndexWidth = 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic lo;
    logic hi;
    logic eq;
  } pair_hit_t;

endpackage

// File: src/nvis_store.sv
// Value table memory with one write port and one registered read port.
module nvis_store import nvis_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_WIDTH = 32,
  parameter int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  output logic [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/nvis_pair_cmp.sv
// Shared compare unit that tests a query value against one neighboring pair.
module nvis_pair_cmp import nvis_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic signed [VALUE_WIDTH-1:0] x,
  input  logic signed [VALUE_WIDTH-1:0] v0,
  input  logic signed [VALUE_WIDTH-1:0] v1,
  output pair_hit_t                     hit
);

  logic signed [VALUE_WIDTH:0] sum;
  logic signed [VALUE_WIDTH:0] twice;
  logic                        lt;
  logic                        gt;

  always_comb begin
    sum   = (VALUE_WIDTH + 1)'(v0) + (VALUE_WIDTH + 1)'(v1);
    twice = {x, 1'b0};
    lt    = twice < sum;
    gt    = twice > sum;
    if (v0 < v1) begin
      hit.lo = (x >= v0) && !gt;
      hit.hi = gt && (x <= v1);
    end else begin
      hit.lo = (x <= v0) && !lt;
      hit.hi = lt && (x >= v1);
    end
    hit.eq = (x == v1);
  end

endmodule

// File: src/nearest_value_index_search.sv
// Top level of the nearest value index search block.
//
// The input channel (in_valid, in_ready, mode, value) takes one word per
// operation: append a value, clear the table, or query the nearest index.
// The output channel (out_valid, out_ready, status, index) returns exactly
// one word for every input word, in order.
// Append, clear and the unused mode need no table read. A query reads one
// table entry per cycle through the single read port of the value memory,
// and stops early at the first matching pair.
// One word is in work at a time; in_ready stays low during a query.
// Reset empties the table and the output register; stored values are
// not cleared, since only entries below the fill count are ever read.
// When the receiver stalls, the result stays in the output register and
// no new word is taken until it has been accepted.
module nearest_value_index_search import nvis_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             mode,
  input  logic signed [31:0]     value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [IndexWidth-1:0]  index
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t                         state;
  state_t                         state_next;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  logic [AW-1:0]                  cur;
  logic [AW-1:0]                  cur_next;
  logic signed [VALUE_WIDTH-1:0]  x;
  logic signed [VALUE_WIDTH-1:0]  prev;
  logic                           prev_load;
  logic                           out_load;
  logic [1:0]                     status_next;
  logic [IndexWidth-1:0]          index_next;
  logic                           accept;
  logic signed [VALUE_WIDTH-1:0]  x_in;
  logic                           we;
  logic [AW-1:0]                  raddr;
  logic signed [VALUE_WIDTH-1:0]  rdata;
  logic [VALUE_WIDTH-1:0]         rdata_raw;
  pair_hit_t                      hit;
  logic                           last;

  assign x_in     = VALUE_WIDTH'(value);
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign rdata    = rdata_raw;
  assign last     = (CW'(cur) == count - CW'(1));

  nvis_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (x_in),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  nvis_pair_cmp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .x   (x),
    .v0  (prev),
    .v1  (rdata),
    .hit (hit)
  );

  always_comb begin
    state_next  = state;
    count_next  = count;
    cur_next    = cur;
    prev_load   = 1'b0;
    out_load    = 1'b0;
    status_next = STATUS_OK;
    index_next  = '0;
    we          = 1'b0;
    raddr       = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_APPEND: begin
              out_load = 1'b1;
              if (count < CW'(TABLE_DEPTH)) begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end else begin
                status_next = STATUS_FULL;
              end
            end
            MODE_CLEAR: begin
              out_load   = 1'b1;
              count_next = '0;
            end
            MODE_QUERY: begin
              if (count == '0) begin
                out_load    = 1'b1;
                status_next = STATUS_NOT_FOUND;
              end else begin
                state_next = S_FIRST;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_FIRST: begin
        prev_load = 1'b1;
        if (count == CW'(1)) begin
          out_load    = 1'b1;
          status_next = hit.eq ? STATUS_OK : STATUS_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          cur_next   = AW'(1);
          raddr      = AW'(1);
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit.lo) begin
          out_load   = 1'b1;
          index_next = IndexWidth'(cur - AW'(1));
          state_next = S_IDLE;
        end else if (hit.hi) begin
          out_load   = 1'b1;
          index_next = IndexWidth'(cur);
          state_next = S_IDLE;
        end else if (last) begin
          out_load    = 1'b1;
          status_next = STATUS_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          prev_load = 1'b1;
          cur_next  = cur + AW'(1);
          raddr     = cur + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (accept) begin
      x <= x_in;
    end
    if (prev_load) begin
      prev <= rdata;
    end
    if (out_load) begin
      status <= status_next;
      index  <= index_next;
    end
  end

endmodule

// File: test/nvis_checker.sv
// Checker that predicts and compares every result word of the nearest value index search.
module nvis_checker import nvis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic signed [31:0]    value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            status,
  input  logic [IndexWidth-1:0] index,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 256;

  typedef struct packed {
    logic [1:0]            status;
    logic [IndexWidth-1:0] index;
  } reply_t;

  logic signed [31:0] stored [Depth];
  int                 fill;
  reply_t             replies_due [$];

  function automatic reply_t apply_word(input logic [1:0] m, input logic signed [31:0] x);
    reply_t             r;
    logic signed [33:0] twice;
    logic signed [33:0] sum;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    bit                 hit;
    int                 at;
    r.status = STATUS_OK;
    r.index  = '0;
    hit      = 1'b0;
    at       = 0;
    case (m)
      MODE_APPEND: begin
        if (fill < Depth) begin
          stored[fill] = x;
          fill++;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      MODE_CLEAR: begin
        fill = 0;
      end
      MODE_QUERY: begin
        if (fill == 1 && stored[0] == x) hit = 1'b1;
        twice = x;
        twice = twice <<< 1;
        for (int i = 0; i + 1 < fill && !hit; i++) begin
          lo  = stored[i];
          hi  = stored[i + 1];
          sum = lo;
          sum = sum + hi;
          if (lo < hi) begin
            if (x >= lo && twice <= sum) begin
              hit = 1'b1;
              at  = i;
            end else if (twice > sum && x <= hi) begin
              hit = 1'b1;
              at  = i + 1;
            end
          end else begin
            if (x <= lo && twice >= sum) begin
              hit = 1'b1;
              at  = i;
            end else if (twice < sum && x >= hi) begin
              hit = 1'b1;
              at  = i + 1;
            end
          end
        end
        if (hit) begin
          r.index = IndexWidth'(at);
        end else begin
          r.status = STATUS_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    fill       = 0;
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      fill = 0;
      replies_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual status %0d index %0d",
                   $time, status, index);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            fail_count++;
          end
          if (index !== want.index) begin
            $display("%0t: index mismatch, expected %0d, actual %0d",
                     $time, want.index, index);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        replies_due.insert(replies_due.size(), apply_word(mode, value));
      end
    end
    pending = replies_due.size();
  end

endmodule

// File: test/tb.sv
// Testbench top that drives the nearest value index search and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nvis_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         ItemTarget  = 1150;
  localparam int         QuietLimit  = 4000;
  localparam int         TableSize   = 256;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            mode;
  logic signed [31:0]    value;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            status;
  logic [IndexWidth-1:0] index;

  int                    fail_count;
  int                    pending;
  int                    sent;
  int                    stall_left;
  int                    quiet;
  bit                    calm;
  bit                    steady;
  int                    shape;
  int                    n_append;
  int                    n_query;
  int                    step;
  logic signed [31:0]    base;
  logic signed [31:0]    shadow [$];

  nearest_value_index_search u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .index     (index)
  );

  nvis_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .index      (index),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!calm && !steady && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] m, input logic signed [31:0] v);
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      mode     <= 2'($urandom);
      value    <= $urandom;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (m == MODE_APPEND && shadow.size() < TableSize) shadow.insert(shadow.size(), v);
    if (m == MODE_CLEAR) shadow.delete();
    sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] shaped_value(input int k);
    logic signed [31:0] v;
    case (shape)
      0:       v = base + 32'(k * step);
      1:       v = base - 32'(k * step);
      2:       v = $urandom;
      3:       v = base + 32'(int'($urandom_range(0, 2)) * step);
      default: v = 32'((int'($urandom_range(0, 8)) - 4) <<< 14);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] pick_probe();
    int                 j;
    logic signed [32:0] mid;
    logic signed [31:0] p;
    j = (shadow.size() > 0) ? $urandom_range(0, shadow.size() - 1) : 0;
    p = $urandom;
    case ($urandom_range(0, 7))
      0: p = $urandom;
      1: begin
        case ($urandom_range(0, 2))
          0:       p = 32'sh7FFFFFFF;
          1:       p = 32'sh80000000;
          default: p = '0;
        endcase
      end
      2, 3: if (shadow.size() > 0) p = shadow[j];
      4: if (shadow.size() > 0) p = shadow[j] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
      default: begin
        if (j + 1 < shadow.size()) begin
          mid = shadow[j];
          mid = mid + shadow[j + 1];
          p   = 32'(mid >>> 1) + 32'($urandom_range(0, 1));
        end
      end
    endcase
    return p;
  endfunction

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    mode       = MODE_APPEND;
    value      = '0;
    calm       = 1'b0;
    steady     = 1'b0;
    sent       = 0;
    stall_left = 0;
    quiet      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table, unused mode, one-entry table, extreme values.
    send_word(MODE_QUERY, 32'sd0);
    send_word(MODE_UNUSED, 32'shFFFFFFFF);
    send_word(MODE_APPEND, 32'sh7FFFFFFF);
    send_word(MODE_QUERY, 32'sh7FFFFFFF);
    send_word(MODE_QUERY, 32'sh7FFFFFFE);
    send_word(MODE_CLEAR, 32'sh55AA55AA);
    send_word(MODE_APPEND, 32'sh80000000);
    send_word(MODE_APPEND, 32'sh7FFFFFFF);
    send_word(MODE_QUERY, 32'shFFFFFFFF);
    send_word(MODE_QUERY, 32'sd0);
    send_word(MODE_QUERY, 32'sh80000000);
    send_word(MODE_APPEND, 32'sh7FFFFFFF);
    send_word(MODE_QUERY, 32'sh7FFFFFFF);
    // Falling pair, rising pair and ties at the midpoint.
    send_word(MODE_CLEAR, 32'sd0);
    send_word(MODE_APPEND, 32'sd10 <<< 16);
    send_word(MODE_APPEND, 32'sd4 <<< 16);
    send_word(MODE_QUERY, 32'sd7 <<< 16);
    send_word(MODE_QUERY, 32'sd5 <<< 16);
    send_word(MODE_QUERY, 32'sd11 <<< 16);
    send_word(MODE_APPEND, 32'sd20 <<< 16);
    send_word(MODE_QUERY, 32'sd12 <<< 16);
    send_word(MODE_QUERY, 32'sd13 <<< 16);
    send_word(MODE_UNUSED, 32'sd0);

    // Fill the table completely, then overflow it and search it end to end.
    send_word(MODE_CLEAR, $urandom);
    repeat (TableSize + 3) send_word(MODE_APPEND, $urandom);
    repeat (8) send_word(MODE_QUERY, pick_probe());

    while (sent < ItemTarget) begin
      if (sent > ItemTarget - 150) calm = 1'b1;
      steady   = ($urandom_range(0, 3) == 0);
      shape    = $urandom_range(0, 4);
      base     = $urandom;
      step     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'h0FFFFFFF)
                                             : $urandom_range(1, 1 << 18);
      n_append = $urandom_range(0, 14);
      n_query  = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) send_word(MODE_CLEAR, $urandom);
      for (int k = 0; k < n_append; k++) begin
        if ($urandom_range(0, 19) == 0) send_word(MODE_UNUSED, $urandom);
        send_word(MODE_APPEND, shaped_value(k));
      end
      repeat (n_query) send_word(MODE_QUERY, pick_probe());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
src/nvis_pkg.sv
src/nvis_store.sv
src/nvis_pair_cmp.sv
src/nearest_value_index_search.sv
test/nvis_checker.sv
test/tb.sv
